[design/ptsprp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptsprp_pkg
// Shared constants and the small prime table for the primality core.
// ----------------------------------------------------------------------------
package ptsprp_pkg;

    localparam int PRIME_ROM_DEPTH = 54;

    // first 54 primes, all fit in eight bits
    function automatic logic [7:0] small_prime(input logic [5:0] idx);
        logic [7:0] p;
        p = 8'd2;
        case (idx)
            6'd0:  p = 8'd2;    6'd1:  p = 8'd3;    6'd2:  p = 8'd5;
            6'd3:  p = 8'd7;    6'd4:  p = 8'd11;   6'd5:  p = 8'd13;
            6'd6:  p = 8'd17;   6'd7:  p = 8'd19;   6'd8:  p = 8'd23;
            6'd9:  p = 8'd29;   6'd10: p = 8'd31;   6'd11: p = 8'd37;
            6'd12: p = 8'd41;   6'd13: p = 8'd43;   6'd14: p = 8'd47;
            6'd15: p = 8'd53;   6'd16: p = 8'd59;   6'd17: p = 8'd61;
            6'd18: p = 8'd67;   6'd19: p = 8'd71;   6'd20: p = 8'd73;
            6'd21: p = 8'd79;   6'd22: p = 8'd83;   6'd23: p = 8'd89;
            6'd24: p = 8'd97;   6'd25: p = 8'd101;  6'd26: p = 8'd103;
            6'd27: p = 8'd107;  6'd28: p = 8'd109;  6'd29: p = 8'd113;
            6'd30: p = 8'd127;  6'd31: p = 8'd131;  6'd32: p = 8'd137;
            6'd33: p = 8'd139;  6'd34: p = 8'd149;  6'd35: p = 8'd151;
            6'd36: p = 8'd157;  6'd37: p = 8'd163;  6'd38: p = 8'd167;
            6'd39: p = 8'd173;  6'd40: p = 8'd179;  6'd41: p = 8'd181;
            6'd42: p = 8'd191;  6'd43: p = 8'd193;  6'd44: p = 8'd197;
            6'd45: p = 8'd199;  6'd46: p = 8'd211;  6'd47: p = 8'd223;
            6'd48: p = 8'd227;  6'd49: p = 8'd229;  6'd50: p = 8'd233;
            6'd51: p = 8'd239;  6'd52: p = 8'd241;  6'd53: p = 8'd251;
            default: p = 8'd251;
        endcase
        return p;
    endfunction

    // modular multiplier request
    typedef struct packed {
        logic go;
    } mm_ctrl_t;

endpackage

[design/ptsprp_modmul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptsprp_modmul
// Bit-serial modular multiplier: a*b mod m, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ptsprp_modmul
    import ptsprp_pkg::*;
#(
    parameter int W = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  mm_ctrl_t     ctrl,
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic [W-1:0] m,
    output logic         done,
    output logic [W-1:0] p
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  a_reg, a_next;
    logic [W-1:0]  b_reg, b_next;
    logic [W-1:0]  m_reg, m_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    dbl;
    logic [W:0]    dbl_red;
    logic [W:0]    sum;
    logic [W-1:0]  acc2;

    // Horner from the top bit: acc = 2*acc (+a), reduced each step
    always_comb
    begin
        dbl     = {acc_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, m_reg}) ? dbl - {1'b0, m_reg} : dbl;
        acc2    = dbl_red[W-1:0];
        sum     = {1'b0, acc2} + (b_reg[W-1] ? {1'b0, a_reg} : '0);
        if (sum >= {1'b0, m_reg})
            sum = sum - {1'b0, m_reg};
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        m_next    = m_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.go)
        begin
            acc_next  = '0;
            a_next    = a;
            b_next    = b;
            m_next    = m;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = sum[W-1:0];
            b_next   = {b_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        m_reg   <= m_next;
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

[design/primality_test_trial_and_sprp_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// primality_test_trial_and_sprp_core
// Trial division by small primes, then a base-2 strong probable-prime test.
// ----------------------------------------------------------------------------
// Usage: drive candidate and pulse start while busy is low; the transaction is
// taken at that edge and busy rises. When the verdict is ready, done strobes
// for exactly one cycle with is_prime valid; busy falls in the same cycle.
// Trial division is bit-serial and tries up to NUM_SMALL_PRIMES primes,
// clamped to between 1 and PRIME_ROM_DEPTH. The SPRP phase uses one
// bit-serial modular multiplier: a set exponent bit costs a multiply and a
// square, a clear one a square alone, and each check step one squaring.
// Candidates below two go straight to the verdict; a factor that is found
// ends the test as soon as its division completes.
// One candidate at a time; a new start is taken in the cycle done shows.
// Reset returns the block to idle and drops any transaction in flight.
// The receiver cannot stall: done is never held.
// ----------------------------------------------------------------------------
module primality_test_trial_and_sprp_core
    import ptsprp_pkg::*;
#(
    parameter int NUM_SMALL_PRIMES = 50,
    parameter int NUMBER_WIDTH     = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [NUMBER_WIDTH-1:0] candidate,
    output logic                    busy,
    output logic                    done,
    output logic                    is_prime
);

    localparam int W   = NUMBER_WIDTH;
    localparam int CW  = $clog2(W + 1);
    localparam int NP  = (NUM_SMALL_PRIMES < 1) ? 1 :
                         ((NUM_SMALL_PRIMES > PRIME_ROM_DEPTH) ? PRIME_ROM_DEPTH
                                                               : NUM_SMALL_PRIMES);
    localparam logic [5:0] LAST_IDX = 6'(NP - 1);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_DIVLD = 9'b000000010,
        S_DIV   = 9'b000000100,
        S_BOUND = 9'b000001000,
        S_SPLIT = 9'b000010000,
        S_EXP   = 9'b000100000,
        S_MUL   = 9'b001000000,
        S_SQR   = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    typedef enum logic [1:0] {
        OP_EXP_MUL = 2'd0,
        OP_EXP_SQR = 2'd1,
        OP_CHK_SQR = 2'd2
    } op_t;

    state_t        state_reg, state_next;
    op_t           op_reg, op_next;
    logic [W-1:0]  n_reg, n_next;
    logic [W-1:0]  sh_reg, sh_next;      // dividend bits / exponent bits
    logic [8:0]    rem_reg, rem_next;    // bit-serial remainder
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [5:0]    idx_reg, idx_next;
    logic [W-1:0]  r_reg, r_next;        // accumulator
    logic [W-1:0]  base_reg, base_next;
    logic [CW-1:0] p_reg, p_next;        // twos in n-1
    logic          res_reg, res_next;
    logic          done_reg, done_next;

    logic [7:0]    prime;
    logic [8:0]    rem_sh;
    logic [W-1:0]  nm1;
    mm_ctrl_t      mm_ctrl;
    logic [W-1:0]  mm_a, mm_b;
    logic          mm_done;
    logic [W-1:0]  mm_p;
    logic [2*W-1:0] top_sq;

    assign prime  = small_prime(idx_reg);
    assign rem_sh = {rem_reg[7:0], sh_reg[W-1]};
    assign nm1    = n_reg - 1'b1;
    assign top_sq = (2*W)'(small_prime(LAST_IDX)) * (2*W)'(small_prime(LAST_IDX));

    ptsprp_modmul #(.W(W)) u_modmul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mm_ctrl),
        .a     (mm_a),
        .b     (mm_b),
        .m     (n_reg),
        .done  (mm_done),
        .p     (mm_p)
    );

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        n_next      = n_reg;
        sh_next     = sh_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        r_next      = r_reg;
        base_next   = base_reg;
        p_next      = p_reg;
        res_next    = res_reg;
        done_next   = 1'b0;
        mm_ctrl.go  = 1'b0;
        mm_a        = r_reg;
        mm_b        = base_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    n_next   = candidate;
                    idx_next = '0;
                    if (candidate < W'(2))
                    begin
                        res_next   = 1'b0;
                        state_next = S_DONE;
                    end
                    else
                        state_next = S_DIVLD;
                end
            end
            S_DIVLD:
            begin
                // stop at first prime not below n
                if (W'(prime) >= n_reg || idx_reg > LAST_IDX)
                    state_next = S_BOUND;
                else
                begin
                    sh_next    = n_reg;
                    rem_next   = '0;
                    cnt_next   = CW'(W);
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                // restoring division, one dividend bit per cycle
                sh_next  = {sh_reg[W-2:0], 1'b0};
                rem_next = (rem_sh >= {1'b0, prime}) ? rem_sh - {1'b0, prime} : rem_sh;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    if (rem_next == '0)
                    begin
                        res_next   = 1'b0;
                        state_next = S_DONE;
                    end
                    else if (idx_reg == LAST_IDX)
                        state_next = S_BOUND;
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_DIVLD;
                    end
                end
            end
            S_BOUND:
            begin
                if (top_sq >= (2*W)'(n_reg))
                begin
                    res_next   = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    sh_next    = nm1;
                    p_next     = '0;
                    state_next = S_SPLIT;
                end
            end
            S_SPLIT:
            begin
                // strip twos from n-1, one per cycle
                if (sh_reg[0] == 1'b0)
                begin
                    sh_next = {1'b0, sh_reg[W-1:1]};
                    p_next  = p_reg + 1'b1;
                end
                else
                begin
                    r_next     = W'(1);
                    base_next  = W'(2);
                    state_next = S_EXP;
                end
            end
            S_EXP:
            begin
                // right-to-left square and multiply
                if (sh_reg == '0)
                begin
                    if (r_reg == W'(1) || r_reg == nm1)
                    begin
                        res_next   = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cnt_next   = CW'(1);
                        state_next = S_SQR;
                    end
                end
                else if (sh_reg[0])
                begin
                    mm_ctrl.go = 1'b1;
                    op_next    = OP_EXP_MUL;
                    state_next = S_MUL;
                end
                else
                begin
                    mm_ctrl.go = 1'b1;
                    mm_a       = base_reg;
                    op_next    = OP_EXP_SQR;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (mm_done)
                begin
                    case (op_reg)
                        OP_EXP_MUL:
                        begin
                            r_next     = mm_p;
                            mm_ctrl.go = 1'b1;
                            mm_a       = base_reg;
                            op_next    = OP_EXP_SQR;
                        end
                        OP_EXP_SQR:
                        begin
                            base_next  = mm_p;
                            sh_next    = {1'b0, sh_reg[W-1:1]};
                            state_next = S_EXP;
                        end
                        OP_CHK_SQR:
                        begin
                            r_next = mm_p;
                            if (mm_p == nm1)
                            begin
                                res_next   = 1'b1;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                cnt_next   = cnt_reg + 1'b1;
                                state_next = S_SQR;
                            end
                        end
                        default:
                        begin
                            state_next = S_SQR;
                        end
                    endcase
                end
            end
            S_SQR:
            begin
                if (cnt_reg >= p_reg)
                begin
                    res_next   = 1'b0;
                    state_next = S_DONE;
                end
                else
                begin
                    mm_ctrl.go = 1'b1;
                    mm_b       = r_reg;
                    op_next    = OP_CHK_SQR;
                    state_next = S_MUL;
                end
            end
            S_DONE:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_EXP_MUL;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            p_reg     <= '0;
            done_reg  <= 1'b0;
            res_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            p_reg     <= p_next;
            done_reg  <= done_next;
            res_reg   <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        sh_reg   <= sh_next;
        rem_reg  <= rem_next;
        r_reg    <= r_next;
        base_reg <= base_next;
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign is_prime = res_reg;

endmodule

[design/ptsprp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptsprp_checker
// Port-level checks on the command handshake of the primality core.
// ----------------------------------------------------------------------------
module ptsprp_checker
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic is_prime
);

    // an accepted transaction raises busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after start");

    // done is a single-cycle strobe
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    // done only ends a transaction
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // done follows busy
    a_done_after: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("done without a transaction");

    // verdict is a known value when strobed
    a_verdict_known: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$isunknown(is_prime))
        else $error("is_prime unknown at done");

endmodule

bind primality_test_trial_and_sprp_core ptsprp_checker u_ptsprp_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .is_prime (is_prime)
);

[dv/tb_primality_test_trial_and_sprp_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_primality_test_trial_and_sprp_core
// Self-checking bench for the trial-division plus base-2 SPRP primality core.
// Candidates are queued by a stimulus block, handed over by a clocked driver
// with random gaps, and each verdict is compared against a local predictor.
// ----------------------------------------------------------------------------
module tb_primality_test_trial_and_sprp_core;

    localparam int NW         = 32;
    localparam int NPRIMES    = 50;
    localparam int DRAIN_CYC  = 6000;
    localparam longint LIMIT  = 64'd8000000;

    logic          clk;
    logic          rst_n;
    logic          start;
    logic [NW-1:0] candidate;
    logic          busy;
    logic          done;
    logic          is_prime;

    primality_test_trial_and_sprp_core #(
        .NUM_SMALL_PRIMES (NPRIMES),
        .NUMBER_WIDTH     (NW)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .candidate (candidate),
        .busy      (busy),
        .done      (done),
        .is_prime  (is_prime)
    );

    // first fifty primes, kept locally for the predictor
    byte unsigned trial_primes [NPRIMES] = '{
        2, 3, 5, 7, 11, 13, 17, 19, 23, 29,
        31, 37, 41, 43, 47, 53, 59, 61, 67, 71,
        73, 79, 83, 89, 97, 101, 103, 107, 109, 113,
        127, 131, 137, 139, 149, 151, 157, 163, 167, 173,
        179, 181, 191, 193, 197, 199, 211, 223, 227, 229
    };

    logic [NW-1:0] pending_candidates [$];
    bit            expected_verdicts [$];
    int            fail_count;
    int            verdicts_seen;
    int            primes_seen;
    bit            stimulus_done;
    bit            hold_for_drain;
    longint        cycle_count;

    // 2^e mod m with 64-bit products
    function automatic longint unsigned pow2_mod(longint unsigned e, longint unsigned m);
        longint unsigned acc;
        longint unsigned b;
        acc = 1 % m;
        b   = 2 % m;
        while (e != 0)
        begin
            if (e[0])
                acc = (acc * b) % m;
            b = (b * b) % m;
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic bit predict_prime(logic [NW-1:0] cand);
        longint unsigned n;
        longint unsigned q;
        longint unsigned r;
        int              p;
        n = cand;
        if (n < 2)
            return 1'b0;
        for (int i = 0; i < NPRIMES && trial_primes[i] < n; i++)
        begin
            if (n % trial_primes[i] == 0)
                return 1'b0;
        end
        if (64'd229 * 64'd229 >= n)
            return 1'b1;
        // strong probable-prime check, base 2
        q = n - 1;
        p = 0;
        while (q != 0 && !q[0])
        begin
            q = q >> 1;
            p++;
        end
        r = pow2_mod(q, n);
        if (r == 1 || r == n - 1)
            return 1'b1;
        for (int i = 1; i < p; i++)
        begin
            r = (r * r) % n;
            if (r == n - 1)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [NW-1:0] rand_word();
        logic [NW-1:0] v;
        case ($urandom_range(0, 3))
            0:       v = $urandom_range(0, 60000);
            1:       v = $urandom_range(52441, 2000000);
            default: v = $urandom;
        endcase
        // odd values reach the SPRP phase far more often
        if ($urandom_range(0, 3) != 0)
            v[0] = 1'b1;
        return v;
    endfunction

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // reset and stimulus
    initial
    begin
        logic [NW-1:0] directed [$];
        rst_n          = 1'b0;
        hold_for_drain = 1'b0;
        stimulus_done  = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // below two, table primes, square bound, SPRP primes, pseudoprimes
        directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd229, 32'd230, 32'd231,
                     32'd233, 32'd52441, 32'd52440, 32'd52439, 32'd52433,
                     32'd2047, 32'd3277, 32'd4033, 32'd25326001,
                     32'hFFFFFFFB, 32'hFFFFFFFF, 32'hFFFFFFFE, 32'h80000000,
                     32'h7FFFFFFF, 32'hAAAAAAAB, 32'h55555555};
        foreach (directed[i])
            pending_candidates.insert(pending_candidates.size(), directed[i]);

        for (int i = 0; i < 300; i++)
        begin
            if (i == 150)
            begin
                // pause until every outstanding verdict has returned
                wait (pending_candidates.size() == 0);
                hold_for_drain = 1'b1;
                wait (expected_verdicts.size() == 0 && !busy && !start);
                hold_for_drain = 1'b0;
            end
            pending_candidates.insert(pending_candidates.size(), rand_word());
        end
        stimulus_done = 1'b1;
    end

    // driver: one transaction per accepted edge, random gap between them
    int gap_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            candidate <= '0;
            gap_left  <= 0;
        end
        else if (start && !busy)
        begin
            expected_verdicts.insert(expected_verdicts.size(), predict_prime(candidate));
            start    <= 1'b0;
            gap_left <= $urandom_range(0, 9);
        end
        else if (!start)
        begin
            if (gap_left > 0)
                gap_left <= gap_left - 1;
            else if (pending_candidates.size() != 0 && !hold_for_drain)
            begin
                candidate <= pending_candidates.pop_front();
                start     <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_verdicts.size() == 0)
            begin
                $error("unexpected verdict: is_prime actual %0b", is_prime);
                fail_count++;
            end
            else
            begin
                bit want;
                want = expected_verdicts.pop_front();
                verdicts_seen++;
                if (want)
                    primes_seen++;
                if (is_prime !== want)
                begin
                    $error("is_prime mismatch: expected %0b actual %0b", want, is_prime);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT)
        begin
            $display("[primality_test_trial_and_sprp_core] ERROR");
            $finish;
        end
    end

    // end of run
    initial
    begin
        fail_count    = 0;
        verdicts_seen = 0;
        primes_seen   = 0;
        cycle_count   = 0;
        wait (stimulus_done);
        wait (pending_candidates.size() == 0 && !start);
        wait (expected_verdicts.size() == 0);
        repeat (DRAIN_CYC) @(posedge clk);
        if (expected_verdicts.size() != 0)
        begin
            $error("%0d verdicts never returned", expected_verdicts.size());
            fail_count++;
        end
        $display("Checked %0d verdicts (%0d prime) over directed edge values and random",
                 verdicts_seen, primes_seen);
        $display("candidates, including SPRP-phase inputs and a drain pause.");
        if (fail_count == 0)
            $display("[primality_test_trial_and_sprp_core] OK");
        else
            $display("[primality_test_trial_and_sprp_core] ERROR");
        $finish;
    end

endmodule
